// ===== src/wtfrm_pkg.sv =====
package wtfrm_pkg;

  localparam int SCAN_W    = 32;
  localparam int SENSOR_W  = 8;
  localparam int LPS_W     = 20;
  localparam int RATE_W    = 32;
  localparam int FRAC_BITS = 16;

  // Divisor constants of the two modes.
  localparam int TURN_DIVISOR   = 98;
  localparam int DIRECT_DIVISOR = 100;

  // 98 * elapsed fits in 39 bits; the partial remainder needs one bit more.
  localparam int DEN_W = SCAN_W + 7;
  localparam int REM_W = DEN_W + 1;

  localparam logic [RATE_W-1:0] RATE_SAT = '1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LPS_W;

  localparam logic [CFG_IDX_W-1:0] REG_TURN_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_SECOND = 1'd1;

  localparam logic             TURN_MODE_RESET = 1'b1;
  localparam logic [LPS_W-1:0] LPS_RESET       = 20'd25000;

  typedef struct packed {
    logic [SCAN_W-1:0]   scan_line;
    logic [SENSOR_W-1:0] sensor_data;
  } sample_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_line_out;
    logic [RATE_W-1:0] flow_rate;
    logic              saturated;
  } result_t;

  // One classified event on its way from the front end to the divider.
  typedef struct packed {
    logic                turn;
    logic [SCAN_W-1:0]   scan_line;
    logic [SCAN_W-1:0]   elapsed;
    logic [SENSOR_W-1:0] sensor_data;
  } task_t;

endpackage

// ===== src/wtfrm_front.sv =====
module wtfrm_front #(
  parameter int WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wtfrm_pkg::sample_t sample,
  input  logic              turn_mode,
  output logic              task_valid,
  input  logic              task_ready,
  output wtfrm_pkg::task_t  task_item
);
  import wtfrm_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SCAN_W-1:0] ring [WINDOW];
  logic [WINDOW-1:0] filled;
  logic [SLOT_W-1:0] newest;
  logic [SLOT_W-1:0] newest_next;
  logic [SLOT_W-1:0] oldest_next;

  logic                stage_valid;
  logic                stage_turn;
  logic [SCAN_W-1:0]   stage_scan;
  logic [SENSOR_W-1:0] stage_sensor;
  logic [SCAN_W-1:0]   rd_data;
  logic                rd_filled;
  logic                accept;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign newest_next = slot_inc(newest);
  assign oldest_next = slot_inc(newest_next);

  assign full   = stage_valid && !task_ready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      newest      <= LAST_SLOT;
      filled      <= '0;
      rd_filled   <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        rd_filled   <= filled[oldest_next];
        if (turn_mode) begin
          newest              <= newest_next;
          filled[newest_next] <= 1'b1;
        end
      end else if (task_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // Stamp ring: one registered read per accepted beat, and one write per beat accepted in turn mode.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_turn   <= turn_mode;
      stage_scan   <= sample.scan_line;
      stage_sensor <= sample.sensor_data;
      rd_data      <= ring[oldest_next];
      if (turn_mode) begin
        ring[newest_next] <= sample.scan_line;
      end
    end
  end

  // A slot never written counts as a stamp of zero: its filled bit is clear, so zero is used.
  assign task_valid            = stage_valid;
  assign task_item.turn        = stage_turn;
  assign task_item.scan_line   = stage_scan;
  assign task_item.elapsed     = stage_scan - (rd_filled ? rd_data : '0);
  assign task_item.sensor_data = stage_sensor;

endmodule

// ===== src/wtfrm_queue.sv =====
module wtfrm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  wtfrm_pkg::task_t wr_item,
  output logic             rd_valid,
  input  logic             rd_take,
  output wtfrm_pkg::task_t rd_item
);
  import wtfrm_pkg::*;

  task_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= ~wptr;
      end
      if (do_rd) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_item;
    end
  end

endmodule

// ===== src/wtfrm_back.sv =====
module wtfrm_back #(
  parameter int WINDOW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       task_valid,
  output logic                       task_take,
  input  wtfrm_pkg::task_t           task_item,
  input  logic [wtfrm_pkg::LPS_W-1:0] lines_per_second,
  output logic                       empty,
  input  logic                       pop,
  output wtfrm_pkg::result_t         result
);
  import wtfrm_pkg::*;

  localparam int NUM_W = FRAC_BITS + LPS_W + $clog2(WINDOW + 1);
  localparam int HI_W  = NUM_W - RATE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]          state;
  logic                turn;
  logic [SCAN_W-1:0]   scan;
  logic [SCAN_W-1:0]   elapsed;
  logic [SENSOR_W-1:0] sensor;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [REM_W-1:0]    rem;
  logic [RATE_W-1:0]   quo;
  logic [4:0]          count;
  logic                sat;
  logic                out_valid;

  logic [REM_W-1:0] num_hi;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] den_ext;
  logic             fits;
  logic             load_out;

  assign num_hi   = REM_W'(num[NUM_W-1 -: HI_W]);
  assign den_ext  = {1'b0, den};
  assign trial    = {rem[DEN_W-1:0], quo[RATE_W-1]};
  assign fits     = (trial >= den_ext);
  assign load_out = (state == ST_DONE) && (!out_valid || pop);

  assign task_take = (state == ST_IDLE);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (task_valid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: state <= ST_CHECK;
        ST_CHECK: begin
          if (num_hi >= den_ext) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (count == 5'd31) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A zero elapsed time gives a zero divisor, which the overflow test
  // already catches: the quotient would not fit in 32 bits.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        turn    <= task_item.turn;
        scan    <= task_item.scan_line;
        elapsed <= task_item.elapsed;
        sensor  <= task_item.sensor_data;
      end
      ST_SETUP: begin
        if (turn) begin
          num <= (NUM_W'(lines_per_second) * NUM_W'(WINDOW)) << FRAC_BITS;
          den <= DEN_W'(elapsed) * DEN_W'(TURN_DIVISOR);
        end else begin
          num <= NUM_W'(sensor) << FRAC_BITS;
          den <= DEN_W'(DIRECT_DIVISOR);
        end
      end
      ST_CHECK: begin
        sat   <= (num_hi >= den_ext);
        rem   <= num_hi;
        quo   <= num[RATE_W-1:0];
        count <= '0;
      end
      ST_DIV: begin
        rem   <= fits ? trial - den_ext : trial;
        quo   <= {quo[RATE_W-2:0], fits};
        count <= count + 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          result.scan_line_out <= scan;
          result.flow_rate     <= sat ? RATE_SAT : quo;
          result.saturated     <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/windowed_turn_flow_rate_meter_unit.sv =====
// An accepted beat passes the front stage, the two-entry queue and the setup, check and divide
// states of the back end before its result is registered on the result ports; when the elapsed
// time is zero or the quotient would overflow, the divider is skipped. The shared divider in the
// back end works on one beat at a time; the queue and the front stage take up to three more early.
// Reset (synchronous, active high) clears the stamp ring's valid bits, sets the
// newest slot to the last one, and loads turn mode with 25000 lines per second.
module windowed_turn_flow_rate_meter_unit #(
  parameter int WINDOW = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  wtfrm_pkg::sample_t              sample,
  output logic                            empty,
  input  logic                            pop,
  output wtfrm_pkg::result_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wtfrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtfrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wtfrm_pkg::*;

  logic             turn_mode;
  logic [LPS_W-1:0] lines_per_second;

  logic  f_valid;
  logic  f_ready;
  task_t f_item;
  logic  q_valid;
  logic  q_take;
  task_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_mode        <= TURN_MODE_RESET;
      lines_per_second <= LPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TURN_MODE:        turn_mode        <= cfg_data[0];
        REG_LINES_PER_SECOND: lines_per_second <= cfg_data[LPS_W-1:0];
        default: ;
      endcase
    end
  end

  wtfrm_front #(.WINDOW(WINDOW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .turn_mode  (turn_mode),
    .task_valid (f_valid),
    .task_ready (f_ready),
    .task_item  (f_item)
  );

  wtfrm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_item  (q_item)
  );

  wtfrm_back #(.WINDOW(WINDOW)) u_back (
    .clk              (clk),
    .rst              (rst),
    .task_valid       (q_valid),
    .task_take        (q_take),
    .task_item        (q_item),
    .lines_per_second (lines_per_second),
    .empty            (empty),
    .pop              (pop),
    .result           (result)
  );

endmodule

// ===== sim/wtfrm_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the flow meter. It keeps
// its own copy of the stamp ring and the registers, predicts the result of
// every accepted sample beat and compares accepted result beats in order.
module wtfrm_checker #(
  parameter int WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  wtfrm_pkg::sample_t               sample,
  input  logic                             empty,
  input  logic                             pop,
  input  wtfrm_pkg::result_t               result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [wtfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtfrm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               checked
);

  import wtfrm_pkg::*;

  localparam int MAX_PRINTED = 40;

  logic              turn_mode_r;
  logic [LPS_W-1:0]  lines_per_sec_r;
  logic [SCAN_W-1:0] stamp_ring [WINDOW];
  int                newest_slot;

  result_t expected_rates [$];
  result_t want;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("checker: %0t %s got %08h expected %08h", $time, what, got, exp_val);
  endtask

  // Advances the meter by one sample beat and returns the rate it must report.
  function automatic result_t meter_step(input sample_t s);
    result_t           r;
    logic [SCAN_W-1:0] elapsed;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [63:0]       quo;
    r.scan_line_out = s.scan_line;
    r.saturated     = 1'b0;
    if (turn_mode_r) begin
      newest_slot = (newest_slot + 1) % WINDOW;
      stamp_ring[newest_slot] = s.scan_line;
      // The slot after the newest holds the oldest stamp of the window.
      elapsed = s.scan_line - stamp_ring[(newest_slot + 1) % WINDOW];
      if (elapsed == '0) begin
        r.flow_rate = RATE_SAT;
        r.saturated = 1'b1;
      end else begin
        num = (64'(WINDOW) * 64'(lines_per_sec_r)) << FRAC_BITS;
        den = 64'(TURN_DIVISOR) * 64'(elapsed);
        quo = num / den;
        if (quo > 64'(RATE_SAT)) begin
          r.flow_rate = RATE_SAT;
          r.saturated = 1'b1;
        end else begin
          r.flow_rate = quo[RATE_W-1:0];
        end
      end
    end else begin
      r.flow_rate = RATE_W'((64'(s.sensor_data) << FRAC_BITS) / 64'(DIRECT_DIVISOR));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      turn_mode_r     = TURN_MODE_RESET;
      lines_per_sec_r = LPS_RESET;
      for (int i = 0; i < WINDOW; i++) stamp_ring[i] = '0;
      newest_slot = WINDOW - 1;
      expected_rates.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TURN_MODE:        turn_mode_r = cfg_data[0];
          REG_LINES_PER_SECOND: lines_per_sec_r = cfg_data[LPS_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) expected_rates.push_back(meter_step(sample));
      if (pop && !empty) begin
        if (expected_rates.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, scan_line_out",
                          result.scan_line_out, '0);
        end else begin
          want = expected_rates.pop_front();
          checked++;
          if (result.scan_line_out !== want.scan_line_out)
            report_mismatch("scan_line_out", result.scan_line_out, want.scan_line_out);
          if (result.flow_rate !== want.flow_rate)
            report_mismatch("flow_rate", result.flow_rate, want.flow_rate);
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", 32'(result.saturated), 32'(want.saturated));
        end
      end
      pending <= expected_rates.size();
    end
  end

endmodule

// ===== sim/tb_windowed_turn_flow_rate_meter_unit.sv =====
`timescale 1ns / 100ps

module tb_windowed_turn_flow_rate_meter_unit;

  import wtfrm_pkg::*;

  localparam int METER_WINDOW    = 16;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 157;
  localparam int HOLD_CYCLES     = 800;
  localparam int DRAIN_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  push;
  logic                  full;
  sample_t               stim;
  logic                  empty;
  logic                  pop;
  result_t               meter_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int checked;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;
  int samples_sent;
  int config_writes;
  int quiet_cycles;
  int zero_run;

  logic [SCAN_W-1:0] stamp;
  logic [SCAN_W-1:0] scan;
  logic              turn;

  windowed_turn_flow_rate_meter_unit #(.WINDOW(METER_WINDOW)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (stim),
    .empty     (empty),
    .pop       (pop),
    .result    (meter_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wtfrm_checker #(.WINDOW(METER_WINDOW)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (stim),
    .empty     (empty),
    .pop       (pop),
    .result    (meter_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random pop, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer_sample(input logic [SCAN_W-1:0] line, input logic [SENSOR_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    stim <= sample_t'{scan_line: line, sensor_data: raw};
    do @(posedge clk); while (full);
    samples_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] mode_word,
                               input logic [CFG_DATA_W-1:0] rate_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TURN_MODE;
    cfg_data  <= mode_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_LINES_PER_SECOND;
    cfg_data  <= rate_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    config_writes += 2;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_line_rate();
    case ($urandom_range(7))
      0:       return 20'd1;
      1:       return 20'd1000000;
      2:       return '1;
      3:       return '0;
      4:       return LPS_RESET;
      5, 6:    return CFG_DATA_W'($urandom_range(1, 1000000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Gap between turn events: mostly realistic spacing, with tiny and zero
  // gaps to reach overflow and zero elapsed time, and rare huge jumps.
  function automatic logic [SCAN_W-1:0] next_gap();
    int r;
    r = $urandom_range(99);
    if (zero_run > 0) begin
      zero_run--;
      return '0;
    end
    if (r < 1) zero_run = METER_WINDOW + 4;
    if (r < 70) return SCAN_W'($urandom_range(500, 20000));
    if (r < 85) return SCAN_W'($urandom_range(1, 4));
    if (r < 92) return '0;
    return SCAN_W'($urandom);
  endfunction

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    pop       <= 1'b0;
    stim      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TURN_MODE;
    cfg_data  <= '0;
    hold_req      = 0;
    samples_sent  = 0;
    config_writes = 0;
    zero_run      = 0;
    send_idle_pct = 10;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset settings. The first event sees
    // an empty ring and a scan line of zero, so its elapsed time is zero and the rate saturates.
    offer_sample(32'h0000_0000, 8'h00);
    offer_sample(32'hFFFF_FFFF, 8'hFF);
    offer_sample(32'h0000_0001, 8'h5A);
    drain_results();
    // Line rate of 1000000 with tiny elapsed times: the quotient overflows at 2.
    load_settings(20'hFFFFF, 20'd1000000);
    offer_sample(32'h0000_0002, 8'hA5);
    offer_sample(32'h0000_0003, 8'h01);
    drain_results();
    load_settings(20'h00001, 20'd0);
    offer_sample(32'h0000_0064, 8'h80);
    offer_sample(32'h0000_0000, 8'h7F);
    drain_results();
    load_settings(20'h00001, 20'hFFFFF);
    offer_sample(32'hFFFF_FF00, 8'hFE);
    drain_results();
    // Direct mode leaves the ring alone; the next turn event must see it intact.
    load_settings(20'hFFFFE, 20'd1);
    offer_sample(32'hFFFF_FFFF, 8'd0);
    offer_sample(32'hAAAA_AAAA, 8'd255);
    offer_sample(32'h5555_5555, 8'd100);
    offer_sample(32'h0000_0000, 8'd99);
    offer_sample(32'h8000_0000, 8'd1);
    offer_sample(32'h7FFF_FFFF, 8'h55);
    offer_sample(32'h0F0F_0F0F, 8'hAA);
    drain_results();
    load_settings(20'h00001, 20'd1);
    offer_sample(32'h1234_5678, 8'h3C);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 10;
        recv_idle_pct = 48;
      end else if (phase < 8) begin
        send_idle_pct = 48;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      turn = (phase % 4 != 3);
      load_settings({(CFG_DATA_W-1)'($urandom), turn}, pick_line_rate());
      stamp = $urandom;
      // Keep offering while the result side is held off so the queue backs up.
      if (phase == 2 || phase == 9) hold_req = HOLD_CYCLES;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 6) begin
          scan = $urandom;
        end else begin
          stamp = stamp + next_gap();
          scan  = stamp;
        end
        offer_sample(scan, SENSOR_W'($urandom_range(255)));
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples over %0d register writes; %0d results compared.",
             samples_sent, config_writes, checked);
    $display("Idling: sender-heavy, receiver-heavy and none; two long receiver hold-offs.");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
